// File: hdl/arprr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP responder package
// Types, field constants and the reply byte table that the responder uses.
// ----------------------------------------------------------------------------
package arprr_pkg;

  localparam logic [15:0] HW_TYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4       = 16'h0800;
  localparam logic [15:0] OPCODE_REQUEST   = 16'h0001;
  localparam logic [15:0] OPCODE_REPLY     = 16'h0002;
  localparam logic [15:0] ETHERTYPE_ARP    = 16'h0806;
  localparam logic [7:0]  MAC_BYTES        = 8'd6;
  localparam logic [7:0]  IPV4_ADDR_BYTES  = 8'd4;

  localparam int unsigned POS_W     = 6;
  localparam logic [POS_W-1:0] POS_MAX    = 6'd63;
  localparam logic [POS_W-1:0] REPLY_LAST = 6'd41;

  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned JOB_PTR_W = 1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_MAC = 1'b0,
    CFG_LOCAL_IP  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } job_status_t;

  function automatic logic [7:0] reply_byte(input job_t job, input logic [POS_W-1:0] idx,
                                            input logic [47:0] mac, input logic [31:0] ip);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      6'd0:  b = job.peer_mac[47:40];
      6'd1:  b = job.peer_mac[39:32];
      6'd2:  b = job.peer_mac[31:24];
      6'd3:  b = job.peer_mac[23:16];
      6'd4:  b = job.peer_mac[15:8];
      6'd5:  b = job.peer_mac[7:0];
      6'd6:  b = mac[47:40];
      6'd7:  b = mac[39:32];
      6'd8:  b = mac[31:24];
      6'd9:  b = mac[23:16];
      6'd10: b = mac[15:8];
      6'd11: b = mac[7:0];
      6'd12: b = ETHERTYPE_ARP[15:8];
      6'd13: b = ETHERTYPE_ARP[7:0];
      6'd14: b = HW_TYPE_ETHERNET[15:8];
      6'd15: b = HW_TYPE_ETHERNET[7:0];
      6'd16: b = PROTO_IPV4[15:8];
      6'd17: b = PROTO_IPV4[7:0];
      6'd18: b = MAC_BYTES;
      6'd19: b = IPV4_ADDR_BYTES;
      6'd20: b = OPCODE_REPLY[15:8];
      6'd21: b = OPCODE_REPLY[7:0];
      6'd22: b = mac[47:40];
      6'd23: b = mac[39:32];
      6'd24: b = mac[31:24];
      6'd25: b = mac[23:16];
      6'd26: b = mac[15:8];
      6'd27: b = mac[7:0];
      6'd28: b = ip[31:24];
      6'd29: b = ip[23:16];
      6'd30: b = ip[15:8];
      6'd31: b = ip[7:0];
      6'd32: b = job.peer_mac[47:40];
      6'd33: b = job.peer_mac[39:32];
      6'd34: b = job.peer_mac[31:24];
      6'd35: b = job.peer_mac[23:16];
      6'd36: b = job.peer_mac[15:8];
      6'd37: b = job.peer_mac[7:0];
      6'd38: b = job.peer_ip[31:24];
      6'd39: b = job.peer_ip[23:16];
      6'd40: b = job.peer_ip[15:8];
      6'd41: b = job.peer_ip[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hdl/arprr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP responder front end
// Tracks the byte position of the received frame, checks the request fields,
// captures the sender addresses and queues a reply job for a passing frame.
// ----------------------------------------------------------------------------
module arprr_front
  import arprr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  input  wire logic [31:0] local_ip,
  output logic             push,
  output job_t             job
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             rejected_r, rejected_nxt;
  logic [47:0]      peer_mac_r, peer_mac_nxt;
  logic [31:0]      peer_ip_r, peer_ip_nxt;
  logic             mismatch;

  always_comb begin
    mismatch = 1'b0;
    unique case (pos_r)
      6'd14:   mismatch = (in_byte != HW_TYPE_ETHERNET[15:8]);
      6'd15:   mismatch = (in_byte != HW_TYPE_ETHERNET[7:0]);
      6'd16:   mismatch = (in_byte != PROTO_IPV4[15:8]);
      6'd17:   mismatch = (in_byte != PROTO_IPV4[7:0]);
      6'd20:   mismatch = (in_byte != OPCODE_REQUEST[15:8]);
      6'd21:   mismatch = (in_byte != OPCODE_REQUEST[7:0]);
      6'd38:   mismatch = (in_byte != local_ip[31:24]);
      6'd39:   mismatch = (in_byte != local_ip[23:16]);
      6'd40:   mismatch = (in_byte != local_ip[15:8]);
      6'd41:   mismatch = (in_byte != local_ip[7:0]);
      default: mismatch = 1'b0;
    endcase
  end

  always_comb begin
    peer_mac_nxt = peer_mac_r;
    peer_ip_nxt  = peer_ip_r;
    pos_nxt      = pos_r;
    rejected_nxt = rejected_r;
    push         = 1'b0;
    if (accept) begin
      if (pos_r >= 6'd22 && pos_r < 6'd28) begin
        peer_mac_nxt = {peer_mac_r[39:0], in_byte};
      end
      if (pos_r >= 6'd28 && pos_r < 6'd32) begin
        peer_ip_nxt = {peer_ip_r[23:0], in_byte};
      end
      if (in_last) begin
        push         = !(rejected_r || mismatch) && (pos_r >= REPLY_LAST);
        pos_nxt      = '0;
        rejected_nxt = 1'b0;
      end else begin
        pos_nxt      = (pos_r == POS_MAX) ? POS_MAX : pos_r + 6'd1;
        rejected_nxt = rejected_r || mismatch;
      end
    end
  end

  assign job.peer_mac = peer_mac_r;
  assign job.peer_ip  = peer_ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      rejected_r <= 1'b0;
      peer_mac_r <= '0;
      peer_ip_r  <= '0;
    end else begin
      pos_r      <= pos_nxt;
      rejected_r <= rejected_nxt;
      peer_mac_r <= peer_mac_nxt;
      peer_ip_r  <= peer_ip_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/arprr_job_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP responder job queue
// A short queue of pending reply jobs between the front and back ends.
// ----------------------------------------------------------------------------
module arprr_job_fifo
  import arprr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  job_t       job_in,
  input  wire logic  pop,
  output job_t       head,
  output job_status_t status
);

  job_t                 mem_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOB_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOB_PTR_W:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign status.not_empty = (count_r != '0);
  assign status.full      = (count_r == (JOB_PTR_W+1)'(JOB_DEPTH));
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign head             = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (JOB_PTR_W+1)'(do_push) - (JOB_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/arprr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP responder back end
// Streams the 42 bytes of a reply for the job at the head of the queue
// through an output register.
// ----------------------------------------------------------------------------
module arprr_back
  import arprr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  job_t             head,
  input  job_status_t      status,
  input  wire logic [47:0] local_mac,
  input  wire logic [31:0] local_ip,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  logic [POS_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic             load;

  assign load = !valid_r || out_ready;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = status.not_empty;
      if (status.not_empty) begin
        byte_nxt = reply_byte(head, idx_r, local_mac, local_ip);
        last_nxt = (idx_r == REPLY_LAST);
        if (idx_r == REPLY_LAST) begin
          idx_nxt = '0;
          pop     = 1'b1;
        end else begin
          idx_nxt = idx_r + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

// File: hdl/arp_request_responder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP request responder
// Answers ARP requests for the local IPv4 address with a 42-byte ARP reply.
// ----------------------------------------------------------------------------
// Received frame bytes are taken at one byte per cycle while the input is not
// stalled. When the last byte of a request for local_ip arrives, a reply job is
// queued and the back end then sends the 42 reply bytes at one byte per cycle
// from its output register while the receiver is ready. Up to two reply jobs wait
// in the queue; while it is full the input stalls. Configuration writes are
// accepted in every cycle and are registered before they take effect.
module arp_request_responder
  import arprr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  in_last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [47:0] local_mac_r, local_mac_nxt;
  logic [31:0] local_ip_r, local_ip_nxt;
  logic        in_accept;
  logic        push;
  logic        pop;
  job_t        job;
  job_t        head;
  job_status_t status;

  assign cfg_ready = 1'b1;
  assign in_ready  = !status.full;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    local_mac_nxt = local_mac_r;
    local_ip_nxt  = local_ip_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOCAL_MAC: local_mac_nxt = cfg_data[47:0];
        CFG_LOCAL_IP:  local_ip_nxt  = cfg_data[31:0];
        default:       local_mac_nxt = local_mac_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mac_r <= '0;
      local_ip_r  <= '0;
    end else begin
      local_mac_r <= local_mac_nxt;
      local_ip_r  <= local_ip_nxt;
    end
  end

  arprr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .local_ip (local_ip_r),
    .push     (push),
    .job      (job)
  );

  arprr_job_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .job_in (job),
    .pop    (pop),
    .head   (head),
    .status (status)
  );

  arprr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .status    (status),
    .local_mac (local_mac_r),
    .local_ip  (local_ip_r),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire

// File: hdl/arprr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP responder port checker
// Checks the reply framing and the flow control seen at the top-level ports.
// ----------------------------------------------------------------------------
module arprr_checker
  import arprr_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  logic [POS_W-1:0] beat_r, beat_nxt;

  always_comb begin
    beat_nxt = beat_r;
    if (out_valid && out_ready) begin
      beat_nxt = (beat_r == REPLY_LAST) ? '0 : beat_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("Stalled reply transaction changed.");

  a_last_on_42nd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (beat_r == REPLY_LAST)))
    else $error("Reply end marker is not on the 42nd byte.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Reply output is valid straight after reset.");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("Input stalled while no reply is being sent.");

endmodule

bind arp_request_responder arprr_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
`default_nettype wire
